// ===== hdl/hsvrgb_pkg.sv =====
`default_nettype none

package hsvrgb_pkg;

   localparam logic [15:0] HUE_FULL_TURN = 16'd46080;
   localparam logic [15:0] HUE_SECTOR    = 16'd7680;
   localparam int          REM_W         = 13;
   localparam int          FRAC_W        = 8;
   localparam int          CHAN_W        = 9;
   localparam int          WEIGHT_W      = 17;
   localparam logic [8:0]  ONE_Q8        = 9'd256;
   localparam logic [17:0] ONE_Q16       = 18'd65536;

   // floor(rem / 30) == (rem * 34953) >> 20 for every rem below one sector
   localparam logic [15:0] FRAC_RECIP = 16'd34953;
   localparam int          FRAC_SHIFT = 20;

   typedef enum logic [2:0] {
      SEC_RED_YEL = 3'd0,
      SEC_YEL_GRN = 3'd1,
      SEC_GRN_CYN = 3'd2,
      SEC_CYN_BLU = 3'd3,
      SEC_BLU_MAG = 3'd4,
      SEC_MAG_RED = 3'd5
   } sector_type;

   typedef struct packed {
      logic              valid;
      sector_type        sector;
      logic [REM_W-1:0]  rem;
      logic [CHAN_W-1:0] sat;
      logic [CHAN_W-1:0] val;
   } sect_stage_type;

   typedef struct packed {
      logic                valid;
      sector_type          sector;
      logic [CHAN_W-1:0]   val;
      logic [CHAN_W-1:0]   p;
      logic [WEIGHT_W-1:0] wq;
      logic [WEIGHT_W-1:0] wt;
   } weight_stage_type;

   function automatic logic [CHAN_W-1:0] clamp_one(input logic [CHAN_W-1:0] x);
      return (x > ONE_Q8) ? ONE_Q8 : x;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/hsvrgb_sector.sv =====
`default_nettype none

module hsvrgb_sector (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   input  wire logic [15:0]                hue,
   input  wire logic [8:0]                 saturation,
   input  wire logic [8:0]                 brightness,
   output hsvrgb_pkg::sect_stage_type      stage_out
);
   import hsvrgb_pkg::*;

   logic [15:0]    hue_wrap;
   logic [15:0]    base;
   logic [15:0]    diff;
   sector_type     sector;
   sect_stage_type stage_in;
   sect_stage_type stage_ff;

   always_comb begin
      hue_wrap = (hue >= HUE_FULL_TURN) ? 16'd0 : hue;
      priority if (hue_wrap >= 16'(5 * HUE_SECTOR)) begin
         sector = SEC_MAG_RED;
         base   = 16'(5 * HUE_SECTOR);
      end else if (hue_wrap >= 16'(4 * HUE_SECTOR)) begin
         sector = SEC_BLU_MAG;
         base   = 16'(4 * HUE_SECTOR);
      end else if (hue_wrap >= 16'(3 * HUE_SECTOR)) begin
         sector = SEC_CYN_BLU;
         base   = 16'(3 * HUE_SECTOR);
      end else if (hue_wrap >= 16'(2 * HUE_SECTOR)) begin
         sector = SEC_GRN_CYN;
         base   = 16'(2 * HUE_SECTOR);
      end else if (hue_wrap >= HUE_SECTOR) begin
         sector = SEC_YEL_GRN;
         base   = HUE_SECTOR;
      end else begin
         sector = SEC_RED_YEL;
         base   = 16'd0;
      end
      diff = hue_wrap - base;

      stage_in.valid  = in_valid;
      stage_in.sector = sector;
      stage_in.rem    = diff[REM_W-1:0];
      stage_in.sat    = clamp_one(saturation);
      stage_in.val    = clamp_one(brightness);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.sector <= stage_in.sector;
      stage_ff.rem    <= stage_in.rem;
      stage_ff.sat    <= stage_in.sat;
      stage_ff.val    <= stage_in.val;
   end

   assign stage_out = stage_ff;

   a_rem_in_sector: assert property (@(posedge clock) disable iff (reset)
      stage_ff.valid |-> ({3'd0, stage_ff.rem} < HUE_SECTOR))
      else $error("sector remainder out of range");

   a_sat_clamped: assert property (@(posedge clock) disable iff (reset)
      stage_ff.valid |-> (stage_ff.sat <= ONE_Q8 && stage_ff.val <= ONE_Q8))
      else $error("saturation or value not clamped");

endmodule

`default_nettype wire

// ===== hdl/hsvrgb_weight.sv =====
`default_nettype none

module hsvrgb_weight (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire hsvrgb_pkg::sect_stage_type  stage_in,
   output hsvrgb_pkg::weight_stage_type     stage_out
);
   import hsvrgb_pkg::*;

   // first stage: fraction by reciprocal multiply, p in parallel
   logic [28:0]         frac_prod;
   logic [17:0]         p_prod;
   logic                valid_a_ff;
   sector_type          sector_a_ff;
   logic [CHAN_W-1:0]   sat_a_ff;
   logic [CHAN_W-1:0]   val_a_ff;
   logic [FRAC_W-1:0]   frac_a_ff;
   logic [CHAN_W-1:0]   p_a_ff;

   // second stage: saturation times fraction and its complement
   logic [17:0]         sf_prod;
   logic [17:0]         sg_prod;
   logic [17:0]         wq_full;
   logic [17:0]         wt_full;
   weight_stage_type    stage_in_b;
   weight_stage_type    stage_ff;

   always_comb begin
      frac_prod = 29'(stage_in.rem) * 29'(FRAC_RECIP);
      p_prod    = 18'(stage_in.val) * 18'(ONE_Q8 - stage_in.sat);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else begin
         valid_a_ff <= stage_in.valid;
      end
      sector_a_ff <= stage_in.sector;
      sat_a_ff    <= stage_in.sat;
      val_a_ff    <= stage_in.val;
      frac_a_ff   <= frac_prod[FRAC_SHIFT +: FRAC_W];
      p_a_ff      <= p_prod[8 +: CHAN_W];
   end

   always_comb begin
      sf_prod = 18'(sat_a_ff) * 18'({1'b0, frac_a_ff});
      sg_prod = 18'(sat_a_ff) * 18'(ONE_Q8 - {1'b0, frac_a_ff});
      wq_full = ONE_Q16 - sf_prod;
      wt_full = ONE_Q16 - sg_prod;

      stage_in_b.valid  = valid_a_ff;
      stage_in_b.sector = sector_a_ff;
      stage_in_b.val    = val_a_ff;
      stage_in_b.p      = p_a_ff;
      stage_in_b.wq     = wq_full[WEIGHT_W-1:0];
      stage_in_b.wt     = wt_full[WEIGHT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in_b.valid;
      end
      stage_ff.sector <= stage_in_b.sector;
      stage_ff.val    <= stage_in_b.val;
      stage_ff.p      <= stage_in_b.p;
      stage_ff.wq     <= stage_in_b.wq;
      stage_ff.wt     <= stage_in_b.wt;
   end

   assign stage_out = stage_ff;

   a_p_below_val: assert property (@(posedge clock) disable iff (reset)
      valid_a_ff |-> (p_a_ff <= val_a_ff))
      else $error("p exceeds value");

   a_weight_range: assert property (@(posedge clock) disable iff (reset)
      stage_ff.valid |-> (stage_ff.wq <= 17'd65536 && stage_ff.wt <= 17'd65536))
      else $error("weight above one");

   a_valid_travels: assert property (@(posedge clock) disable iff (reset)
      stage_in.valid |=> ##1 stage_ff.valid)
      else $error("valid bit lost in weight stages");

endmodule

`default_nettype wire

// ===== hdl/hsvrgb_blend.sv =====
`default_nettype none

module hsvrgb_blend (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire hsvrgb_pkg::weight_stage_type  stage_in,
   output logic                               out_valid,
   output logic [8:0]                         red,
   output logic [8:0]                         green,
   output logic [8:0]                         blue
);
   import hsvrgb_pkg::*;

   logic [25:0]       q_prod;
   logic [25:0]       t_prod;
   logic [CHAN_W-1:0] q;
   logic [CHAN_W-1:0] t;
   logic [CHAN_W-1:0] v;
   logic [CHAN_W-1:0] p;
   logic [CHAN_W-1:0] red_in;
   logic [CHAN_W-1:0] green_in;
   logic [CHAN_W-1:0] blue_in;
   logic              valid_ff;
   logic [CHAN_W-1:0] red_ff;
   logic [CHAN_W-1:0] green_ff;
   logic [CHAN_W-1:0] blue_ff;

   always_comb begin
      q_prod = 26'(stage_in.val) * 26'(stage_in.wq);
      t_prod = 26'(stage_in.val) * 26'(stage_in.wt);
      q      = q_prod[16 +: CHAN_W];
      t      = t_prod[16 +: CHAN_W];
      v      = stage_in.val;
      p      = stage_in.p;

      // zero saturation needs no special arm: p, q and t all equal v then
      unique case (stage_in.sector)
         SEC_RED_YEL: begin red_in = v; green_in = t; blue_in = p; end
         SEC_YEL_GRN: begin red_in = q; green_in = v; blue_in = p; end
         SEC_GRN_CYN: begin red_in = p; green_in = v; blue_in = t; end
         SEC_CYN_BLU: begin red_in = p; green_in = q; blue_in = v; end
         SEC_BLU_MAG: begin red_in = t; green_in = p; blue_in = v; end
         default:     begin red_in = v; green_in = p; blue_in = q; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= stage_in.valid;
      end
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
   end

   assign out_valid = valid_ff;
   assign red       = red_ff;
   assign green     = green_ff;
   assign blue      = blue_ff;

   a_max_is_value: assert property (@(posedge clock) disable iff (reset)
      stage_in.valid |=> (red_ff == $past(stage_in.val) || green_ff == $past(stage_in.val)
                          || blue_ff == $past(stage_in.val)))
      else $error("no channel equals value");

   a_chan_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (red_ff <= ONE_Q8 && green_ff <= ONE_Q8 && blue_ff <= ONE_Q8))
      else $error("channel above one");

endmodule

`default_nettype wire

// ===== hdl/hsv_to_rgb_converter.sv =====
// channel   direction  transfer when         payload
// request   in         start && !busy       req_hue, req_saturation, req_brightness
// response  out        rsp_strobe           rsp_red, rsp_green, rsp_blue
//
// one pixel per clock while reset is low; each response follows its request transfer
// through four register stages: sector split, fraction and p multiply,
// weight multiply, q and t multiply with channel select
// reset clears only the valid bits; busy is high during reset and low otherwise
// the receiver cannot stall, so the pipeline always advances
`default_nettype none

module hsv_to_rgb_converter (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire logic [15:0] req_hue,
   input  wire logic [8:0]  req_saturation,
   input  wire logic [8:0]  req_brightness,
   output logic            rsp_strobe,
   output logic [8:0]      rsp_red,
   output logic [8:0]      rsp_green,
   output logic [8:0]      rsp_blue
);
   import hsvrgb_pkg::*;

   logic             req_transfer;
   sect_stage_type   sect_stage;
   weight_stage_type weight_stage;

   assign busy         = reset;
   assign req_transfer = start && !busy;

   hsvrgb_sector u_sector (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_transfer),
      .hue        (req_hue),
      .saturation (req_saturation),
      .brightness (req_brightness),
      .stage_out  (sect_stage)
   );

   hsvrgb_weight u_weight (
      .clock     (clock),
      .reset     (reset),
      .stage_in  (sect_stage),
      .stage_out (weight_stage)
   );

   hsvrgb_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .stage_in  (weight_stage),
      .out_valid (rsp_strobe),
      .red       (rsp_red),
      .green     (rsp_green),
      .blue      (rsp_blue)
   );

endmodule

`default_nettype wire

// ===== dv/tb_hsv_to_rgb_converter.sv =====
`default_nettype none

module tb_hsv_to_rgb_converter;
   import hsvrgb_pkg::*;

   localparam int HUE_PER_STEP  = 30;
   localparam int RANDOM_PIXELS = 700;
   localparam int DRAIN_EVERY   = 200;
   localparam int IDLE_LIMIT    = 2000;
   localparam int TAIL_CYCLES   = 8;
   localparam int NUM_ROWS      = 22;

   typedef struct packed {
      logic [8:0] red;
      logic [8:0] green;
      logic [8:0] blue;
   } rgb_type;

   typedef struct packed {
      logic [15:0] hue;
      logic [8:0]  sat;
      logic [8:0]  bri;
      logic        typed;
      logic [8:0]  red;
      logic [8:0]  green;
      logic [8:0]  blue;
   } pixel_row_type;

   // typed rows carry their rgb; the rest go through the predictor
   localparam pixel_row_type PIXEL_ROWS [NUM_ROWS] = '{
      '{16'd0,     9'd0,   9'd0,   1'b1, 9'd0,   9'd0,   9'd0},
      '{16'd0,     9'd0,   9'd256, 1'b1, 9'd256, 9'd256, 9'd256},
      '{16'd65535, 9'd0,   9'd511, 1'b1, 9'd256, 9'd256, 9'd256},
      '{16'd0,     9'd256, 9'd256, 1'b1, 9'd256, 9'd0,   9'd0},
      '{16'd46080, 9'd256, 9'd256, 1'b1, 9'd256, 9'd0,   9'd0},
      '{16'd65535, 9'd511, 9'd511, 1'b1, 9'd256, 9'd0,   9'd0},
      '{16'd7680,  9'd256, 9'd256, 1'b1, 9'd256, 9'd256, 9'd0},
      '{16'd15360, 9'd256, 9'd256, 1'b1, 9'd0,   9'd256, 9'd0},
      '{16'd23040, 9'd256, 9'd256, 1'b1, 9'd0,   9'd256, 9'd256},
      '{16'd30720, 9'd256, 9'd256, 1'b1, 9'd0,   9'd0,   9'd256},
      '{16'd38400, 9'd256, 9'd256, 1'b1, 9'd256, 9'd0,   9'd256},
      '{16'd0,     9'd256, 9'd0,   1'b1, 9'd0,   9'd0,   9'd0},
      '{16'd46079, 9'd256, 9'd256, 1'b0, 9'd0,   9'd0,   9'd0},
      '{16'd7679,  9'd256, 9'd256, 1'b0, 9'd0,   9'd0,   9'd0},
      '{16'd3840,  9'd128, 9'd200, 1'b0, 9'd0,   9'd0,   9'd0},
      '{16'd19200, 9'd300, 9'd128, 1'b0, 9'd0,   9'd0,   9'd0},
      '{16'd26880, 9'd1,   9'd1,   1'b0, 9'd0,   9'd0,   9'd0},
      '{16'd34560, 9'd255, 9'd257, 1'b0, 9'd0,   9'd0,   9'd0},
      '{16'd42240, 9'd200, 9'd511, 1'b0, 9'd0,   9'd0,   9'd0},
      '{16'd46081, 9'd100, 9'd100, 1'b0, 9'd0,   9'd0,   9'd0},
      '{16'd1,     9'd511, 9'd255, 1'b0, 9'd0,   9'd0,   9'd0},
      '{16'd32767, 9'd64,  9'd256, 1'b0, 9'd0,   9'd0,   9'd0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [15:0] req_hue = '0;
   logic [8:0]  req_saturation = '0;
   logic [8:0]  req_brightness = '0;
   logic        rsp_strobe;
   logic [8:0]  rsp_red;
   logic [8:0]  rsp_green;
   logic [8:0]  rsp_blue;

   rgb_type rgb_next = '0;
   rgb_type rgb_expected [$];
   int      errors = 0;
   int      idle_cycles = 0;

   hsv_to_rgb_converter dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_brightness (req_brightness),
      .rsp_strobe     (rsp_strobe),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic rgb_type rgb_of_hsv(input logic [15:0] hue, input logic [8:0] sat_in,
                                          input logic [8:0] bri_in);
      int unsigned s, v, f, p, q, t;
      logic [15:0] h;
      sector_type  sect;
      rgb_type     px;
      s = (sat_in > ONE_Q8) ? ONE_Q8 : sat_in;
      v = (bri_in > ONE_Q8) ? ONE_Q8 : bri_in;
      h = (hue >= HUE_FULL_TURN) ? 16'd0 : hue;
      sect = sector_type'(3'(h / HUE_SECTOR));
      f = (h % HUE_SECTOR) / HUE_PER_STEP;
      p = (v * (ONE_Q8 - s)) >> 8;
      q = (v * (ONE_Q16 - s * f)) >> 16;
      t = (v * (ONE_Q16 - s * (ONE_Q8 - f))) >> 16;
      if (s == 0) begin
         px = '{9'(v), 9'(v), 9'(v)};
      end else begin
         case (sect)
            SEC_RED_YEL: px = '{9'(v), 9'(t), 9'(p)};
            SEC_YEL_GRN: px = '{9'(q), 9'(v), 9'(p)};
            SEC_GRN_CYN: px = '{9'(p), 9'(v), 9'(t)};
            SEC_CYN_BLU: px = '{9'(p), 9'(q), 9'(v)};
            SEC_BLU_MAG: px = '{9'(t), 9'(p), 9'(v)};
            default:     px = '{9'(v), 9'(p), 9'(q)};
         endcase
      end
      return px;
   endfunction

   // mostly in-range fractions, with zero, exactly one and overrange mixed in
   function automatic logic [8:0] pick_fraction();
      logic [8:0] x;
      case ($urandom_range(0, 9))
         0:       x = 9'd0;
         1:       x = ONE_Q8;
         2:       x = 9'($urandom_range(257, 511));
         default: x = 9'($urandom_range(1, 255));
      endcase
      return x;
   endfunction

   // returns at the edge that takes the transfer
   task automatic send_pixel(input logic [15:0] hue, input logic [8:0] sat,
                             input logic [8:0] bri, input rgb_type want);
      req_hue        <= hue;
      req_saturation <= sat;
      req_brightness <= bri;
      rgb_next       <= want;
      start          <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic send_random_pixel();
      logic [15:0] hue;
      logic [8:0]  sat;
      logic [8:0]  bri;
      case ($urandom_range(0, 9))
         0:       hue = 16'($urandom_range(46080, 65535));
         1:       hue = 16'(HUE_SECTOR * $urandom_range(0, 5) + $urandom_range(0, 2));
         2:       hue = 16'(HUE_SECTOR * $urandom_range(1, 6) - 1 - $urandom_range(0, 2));
         default: hue = 16'($urandom_range(0, 46079));
      endcase
      sat = pick_fraction();
      bri = pick_fraction();
      send_pixel(hue, sat, bri, rgb_of_hsv(hue, sat, bri));
   endtask

   task automatic hold_until_drained();
      start <= 1'b0;
      @(posedge clock);
      while (rgb_expected.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      rgb_type want;
      if (start && !busy) rgb_expected.push_back(rgb_next);
      if (rsp_strobe) begin
         if (rgb_expected.size() == 0) begin
            $error("unexpected result: red %0d green %0d blue %0d", rsp_red, rsp_green, rsp_blue);
            errors++;
         end else begin
            want = rgb_expected.pop_front();
            if (rsp_red !== want.red) begin
               $error("red: expected %0d, got %0d", want.red, rsp_red);
               errors++;
            end
            if (rsp_green !== want.green) begin
               $error("green: expected %0d, got %0d", want.green, rsp_green);
               errors++;
            end
            if (rsp_blue !== want.blue) begin
               $error("blue: expected %0d, got %0d", want.blue, rsp_blue);
               errors++;
            end
         end
      end
      if ((start && !busy) || rsp_strobe) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      int sent;
      int burst;
      int gap;
      int next_drain;
      pixel_row_type row;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_ROWS; i++) begin
         row = PIXEL_ROWS[i];
         send_pixel(row.hue, row.sat, row.bri,
                    row.typed ? rgb_type'({row.red, row.green, row.blue})
                              : rgb_of_hsv(row.hue, row.sat, row.bri));
         if ($urandom_range(0, 2) == 0) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
      hold_until_drained();

      sent = 0;
      next_drain = DRAIN_EVERY;
      while (sent < RANDOM_PIXELS) begin
         burst = $urandom_range(1, 16);
         repeat (burst) begin
            send_random_pixel();
            sent++;
         end
         if (sent >= next_drain) begin
            hold_until_drained();
            next_drain += DRAIN_EVERY;
         end else begin
            // some bursts run straight into the next one
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
               start <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end

      hold_until_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
hdl/hsvrgb_pkg.sv
hdl/hsvrgb_sector.sv
hdl/hsvrgb_weight.sv
hdl/hsvrgb_blend.sv
hdl/hsv_to_rgb_converter.sv
dv/tb_hsv_to_rgb_converter.sv
